// File: rtl/huffman_table_bit_count_select_defines.svh
// assertion macros shared by the huffman cost counter rtl
`ifndef HUFFMAN_TABLE_BIT_COUNT_SELECT_DEFINES_SVH
`define HUFFMAN_TABLE_BIT_COUNT_SELECT_DEFINES_SVH

// same-cycle implication, held off during reset
`define HTBCS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("htbcs assertion failed");

// next-cycle implication, held off during reset
`define HTBCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("htbcs assertion failed");

`endif

// File: rtl/htbcs_pkg.sv
// types, constants and the quad cost rom of the huffman cost counter
package htbcs_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int CLAMP_LIMIT_DEF = 15;
    localparam int COST_WIDTH_DEF  = 16;

    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 24;
    localparam int MODE_W      = 2;
    localparam int ADDR_IN_W   = 8;
    localparam int LOAD_DATA_W = 64;
    localparam int VALUE_W     = 13;
    localparam int QUAD_W      = 4;
    localparam int LANE_W      = 16;
    localparam int NUM_CAND    = 4;
    localparam int MIN_BITS_W  = 16;
    localparam int CHOICE_W    = 2;
    localparam int ROM_W       = 32;

    localparam int LOAD_ADDR_LSB = 0;
    localparam int LOAD_DATA_LSB = 8;
    localparam int VALUE_X_LSB   = 72;
    localparam int VALUE_Y_LSB   = 85;
    localparam int QUAD_LSB      = 98;

    // widest linear pair address: 13-bit value shifted by up to 7, plus a carry
    localparam int ADDR_W      = 21;
    localparam int QUEUE_DEPTH = 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;
    localparam int SHIFT_W     = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_VARIANT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLAMP     = 2'd2;

    localparam logic [1:0]         VARIANT_PAIR2 = 2'd0;
    localparam logic [1:0]         VARIANT_PAIR4 = 2'd1;
    localparam logic [1:0]         VARIANT_QUAD  = 2'd2;
    localparam logic [SHIFT_W-1:0] ROW_WIDTH_RST = 3'd4;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACCUM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_LOAD,
        KIND_LOOKUP,
        KIND_DIRECT,
        KIND_EMPTY
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [ADDR_IN_W-1:0]   index;
        logic [LOAD_DATA_W-1:0] data;
        logic                   last;
    } q_entry_t;

    typedef struct packed {
        logic [1:0]         variant;
        logic [SHIFT_W-1:0] row_width_log2;
        logic               clamp_enable;
    } cfg_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [ROM_W-1:0] quad_rom(input logic [QUAD_W-1:0] pattern);
        logic [ROM_W-1:0] v;
        unique case (pattern)
            4'd0:    v = 32'h0004_0001;
            4'd1:    v = 32'h0005_0005;
            4'd2:    v = 32'h0005_0005;
            4'd3:    v = 32'h0006_0007;
            4'd4:    v = 32'h0005_0005;
            4'd5:    v = 32'h0006_0008;
            4'd6:    v = 32'h0006_0007;
            4'd7:    v = 32'h0007_0009;
            4'd8:    v = 32'h0005_0005;
            4'd9:    v = 32'h0006_0007;
            4'd10:   v = 32'h0006_0007;
            4'd11:   v = 32'h0007_0009;
            4'd12:   v = 32'h0006_0007;
            4'd13:   v = 32'h0007_0009;
            4'd14:   v = 32'h0007_0009;
            default: v = 32'h0008_000A;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/htbcs_ram.sv
// generic single-port ram with registered read
module htbcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/htbcs_front.sv
// front end: beat intake, classification and pair address pipeline
module htbcs_front #(
    parameter int TABLE_DEPTH = htbcs_pkg::TABLE_DEPTH_DEF,
    parameter int CLAMP_LIMIT = htbcs_pkg::CLAMP_LIMIT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  htbcs_pkg::cfg_t                   cfg,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [htbcs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    input  logic [htbcs_pkg::MODE_W-1:0]      s_axis_tuser,
    input  logic                              s_axis_tlast,
    input  logic                              q_pop,
    output logic                              q_push,
    output htbcs_pkg::q_entry_t               q_push_entry
);

    localparam int ADDR_W = htbcs_pkg::ADDR_W;
    localparam int MULT   = (1 << ADDR_W) / TABLE_DEPTH;
    localparam int M_W    = $clog2(MULT + 1);
    localparam int Q_W    = ADDR_W - $clog2(TABLE_DEPTH) + 1;
    localparam int D_W    = $clog2(TABLE_DEPTH + 1);
    localparam int P_W    = Q_W + D_W;
    localparam int R_W    = D_W + 1;
    localparam int PR_W   = ADDR_W + M_W;
    localparam int CR_W   = $clog2(htbcs_pkg::QUEUE_DEPTH + 1);

    logic [CR_W-1:0] credit_reg, credit_next;
    logic            accept;

    logic [htbcs_pkg::ADDR_IN_W-1:0]   ld_addr;
    logic [htbcs_pkg::LOAD_DATA_W-1:0] ld_data;
    logic [htbcs_pkg::VALUE_W-1:0]     val_x, val_y, row, col;
    logic [htbcs_pkg::QUAD_W-1:0]      quad;
    logic [ADDR_W-1:0]                 lin_addr;
    htbcs_pkg::q_entry_t               e_in;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    htbcs_pkg::q_entry_t e1_reg, e2_reg, e3_reg, e4_reg;
    logic [ADDR_W-1:0]   a1_reg, a2_reg, a3_reg;
    logic [PR_W-1:0]     prod2_reg;
    logic [P_W-1:0]      p3_reg;
    logic [R_W-1:0]      r4_reg;
    logic [Q_W-1:0]      q2;
    logic [ADDR_W-1:0]   diff3;
    logic [R_W-1:0]      r_fix;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = credit_reg < CR_W'(htbcs_pkg::QUEUE_DEPTH);

    // one credit per beat in flight between intake and the back end
    always_comb begin
        credit_next = credit_reg;
        if (accept && !q_pop) begin
            credit_next = credit_reg + CR_W'(1);
        end else if (!accept && q_pop) begin
            credit_next = credit_reg - CR_W'(1);
        end
    end

    assign ld_addr = s_axis_tdata[htbcs_pkg::LOAD_ADDR_LSB +: htbcs_pkg::ADDR_IN_W];
    assign ld_data = s_axis_tdata[htbcs_pkg::LOAD_DATA_LSB +: htbcs_pkg::LOAD_DATA_W];
    assign val_x   = s_axis_tdata[htbcs_pkg::VALUE_X_LSB +: htbcs_pkg::VALUE_W];
    assign val_y   = s_axis_tdata[htbcs_pkg::VALUE_Y_LSB +: htbcs_pkg::VALUE_W];
    assign quad    = s_axis_tdata[htbcs_pkg::QUAD_LSB +: htbcs_pkg::QUAD_W];

    assign row = (cfg.clamp_enable && val_x > htbcs_pkg::VALUE_W'(CLAMP_LIMIT))
               ? htbcs_pkg::VALUE_W'(CLAMP_LIMIT) : val_x;
    assign col = (cfg.clamp_enable && val_y > htbcs_pkg::VALUE_W'(CLAMP_LIMIT))
               ? htbcs_pkg::VALUE_W'(CLAMP_LIMIT) : val_y;
    assign lin_addr = (ADDR_W'(row) << cfg.row_width_log2) + ADDR_W'(col);

    always_comb begin
        e_in.kind  = htbcs_pkg::KIND_NOP;
        e_in.index = ld_addr;
        e_in.data  = ld_data;
        e_in.last  = s_axis_tlast;
        unique case (s_axis_tuser)
            htbcs_pkg::MODE_LOAD: begin
                if (32'(ld_addr) < TABLE_DEPTH) begin
                    e_in.kind = htbcs_pkg::KIND_LOAD;
                end
            end
            htbcs_pkg::MODE_ACCUM: begin
                if (cfg.variant == htbcs_pkg::VARIANT_QUAD) begin
                    e_in.kind = htbcs_pkg::KIND_DIRECT;
                    e_in.data = htbcs_pkg::LOAD_DATA_W'(htbcs_pkg::quad_rom(quad));
                end else begin
                    e_in.kind = htbcs_pkg::KIND_LOOKUP;
                end
            end
            htbcs_pkg::MODE_EMPTY: begin
                e_in.kind = htbcs_pkg::KIND_EMPTY;
            end
            default: begin
                e_in.kind = htbcs_pkg::KIND_NOP;
            end
        endcase
    end

    // address modulo table depth: reciprocal multiply, back-multiply, one correction
    assign q2    = prod2_reg[ADDR_W +: Q_W];
    assign diff3 = a3_reg - p3_reg[ADDR_W-1:0];
    assign r_fix = (r4_reg >= R_W'(TABLE_DEPTH)) ? r4_reg - R_W'(TABLE_DEPTH) : r4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
        end else begin
            credit_reg <= credit_next;
            v1_reg     <= accept;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            v4_reg     <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        e1_reg    <= e_in;
        a1_reg    <= lin_addr;
        e2_reg    <= e1_reg;
        a2_reg    <= a1_reg;
        prod2_reg <= PR_W'(a1_reg) * PR_W'(MULT);
        e3_reg    <= e2_reg;
        a3_reg    <= a2_reg;
        p3_reg    <= P_W'(q2) * P_W'(TABLE_DEPTH);
        e4_reg    <= e3_reg;
        r4_reg    <= diff3[R_W-1:0];
    end

    always_comb begin
        q_push       = v4_reg;
        q_push_entry = e4_reg;
        if (e4_reg.kind == htbcs_pkg::KIND_LOOKUP) begin
            q_push_entry.index = htbcs_pkg::ADDR_IN_W'(r_fix);
        end
    end

endmodule

// File: rtl/htbcs_queue.sv
// small flop queue between the front end and the back end
module htbcs_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  htbcs_pkg::q_entry_t   push_entry,
    input  logic                  pop,
    output htbcs_pkg::q_entry_t   head_entry,
    output htbcs_pkg::q_status_t  status
);

    localparam int PTR_W = $clog2(htbcs_pkg::QUEUE_DEPTH);

    htbcs_pkg::q_entry_t mem_reg [htbcs_pkg::QUEUE_DEPTH];
    logic [PTR_W:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W:0]      rd_ptr_reg, rd_ptr_next;

    assign wr_ptr_next = push ? wr_ptr_reg + (PTR_W+1)'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + (PTR_W+1)'(1) : rd_ptr_reg;

    assign status.empty = wr_ptr_reg == rd_ptr_reg;
    assign status.full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W])
                       && (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);
    assign head_entry   = mem_reg[rd_ptr_reg[PTR_W-1:0]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg[PTR_W-1:0]] <= push_entry;
        end
    end

endmodule

// File: rtl/htbcs_back.sv
// back end: cost table access, saturating sums, table choice and result register
module htbcs_back #(
    parameter int TABLE_DEPTH = htbcs_pkg::TABLE_DEPTH_DEF,
    parameter int COST_WIDTH  = htbcs_pkg::COST_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [1:0]                      variant,
    input  htbcs_pkg::q_entry_t             head_entry,
    input  logic                            q_empty,
    output logic                            q_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [htbcs_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int NC    = htbcs_pkg::NUM_CAND;

    logic adv;
    logic ram_en, ram_we;
    logic [htbcs_pkg::LOAD_DATA_W-1:0] ram_rdata, entry_data;

    logic                b1_valid_reg;
    htbcs_pkg::q_entry_t b1_entry_reg;

    logic [COST_WIDTH-1:0] sum_reg [NC];
    logic [COST_WIDTH-1:0] sum_next [NC];
    logic [COST_WIDTH-1:0] fin_reg [NC];
    logic [COST_WIDTH-1:0] fin_next [NC];
    logic [COST_WIDTH-1:0] sat [NC];
    logic                  b2_valid_reg, b2_valid_next;
    logic                  b2_empty_reg, b2_empty_next;

    logic [COST_WIDTH-1:0] best;
    logic [htbcs_pkg::CHOICE_W-1:0] choice;

    logic                             out_valid_reg;
    logic [htbcs_pkg::MIN_BITS_W-1:0] out_min_reg;
    logic [htbcs_pkg::CHOICE_W-1:0]   out_choice_reg;

    assign adv    = !out_valid_reg || m_axis_tready;
    assign q_pop  = adv && !q_empty;
    assign ram_en = q_pop && (head_entry.kind == htbcs_pkg::KIND_LOAD
                           || head_entry.kind == htbcs_pkg::KIND_LOOKUP);
    assign ram_we = head_entry.kind == htbcs_pkg::KIND_LOAD;

    htbcs_ram #(
        .WIDTH (htbcs_pkg::LOAD_DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_cost_table (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (head_entry.index[IDX_W-1:0]),
        .wdata (head_entry.data),
        .rdata (ram_rdata)
    );

    assign entry_data = (b1_entry_reg.kind == htbcs_pkg::KIND_LOOKUP)
                      ? ram_rdata : b1_entry_reg.data;

    always_comb begin
        logic [COST_WIDTH:0] s;
        for (int k = 0; k < NC; k++) begin
            s = {1'b0, sum_reg[k]}
              + {1'b0, entry_data[k*htbcs_pkg::LANE_W +: COST_WIDTH]};
            sat[k] = s[COST_WIDTH] ? {COST_WIDTH{1'b1}} : s[COST_WIDTH-1:0];
        end
    end

    always_comb begin
        sum_next      = sum_reg;
        fin_next      = fin_reg;
        b2_valid_next = b2_valid_reg;
        b2_empty_next = b2_empty_reg;
        if (adv) begin
            b2_valid_next = 1'b0;
            b2_empty_next = 1'b0;
            if (b1_valid_reg) begin
                unique case (b1_entry_reg.kind)
                    htbcs_pkg::KIND_LOOKUP, htbcs_pkg::KIND_DIRECT: begin
                        sum_next = sat;
                        if (b1_entry_reg.last) begin
                            fin_next      = sat;
                            b2_valid_next = 1'b1;
                            for (int k = 0; k < NC; k++) begin
                                sum_next[k] = '0;
                            end
                        end
                    end
                    htbcs_pkg::KIND_EMPTY: begin
                        b2_valid_next = 1'b1;
                        b2_empty_next = 1'b1;
                        for (int k = 0; k < NC; k++) begin
                            sum_next[k] = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ties go to the higher candidate
    always_comb begin
        if (fin_reg[0] < fin_reg[1]) begin
            best   = fin_reg[0];
            choice = 2'd0;
        end else begin
            best   = fin_reg[1];
            choice = 2'd1;
        end
        if (variant == htbcs_pkg::VARIANT_PAIR4) begin
            if (fin_reg[2] <= best) begin
                best   = fin_reg[2];
                choice = 2'd2;
            end
            if (fin_reg[3] <= best) begin
                best   = fin_reg[3];
                choice = 2'd3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NC; k++) begin
                sum_reg[k] <= '0;
            end
        end else begin
            if (adv) begin
                b1_valid_reg  <= q_pop;
                out_valid_reg <= b2_valid_reg;
            end
            b2_valid_reg <= b2_valid_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_reg      <= fin_next;
        b2_empty_reg <= b2_empty_next;
        if (q_pop) begin
            b1_entry_reg <= head_entry;
        end
        if (adv) begin
            out_min_reg    <= b2_empty_reg ? '0 : htbcs_pkg::MIN_BITS_W'(best);
            out_choice_reg <= b2_empty_reg ? '0 : choice;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(htbcs_pkg::M_TDATA_W - htbcs_pkg::MIN_BITS_W
                             - htbcs_pkg::CHOICE_W)'(0), out_choice_reg, out_min_reg};

endmodule

// File: rtl/huffman_table_bit_count_select.sv
// Huffman cost counter: takes one beat per clock while its queue has room. Every beat goes
// through a fixed four-stage front end (the pair address is reduced modulo the table depth by
// a reciprocal multiply), a queue of eight beats, and a three-stage back end (cost table ram
// with registered read, saturating sums, choice compare and result register). A stalled
// result holds the back end only; the front end keeps taking beats until the queue is full.
// The cost table needs no clearing pass after reset, as its entries must be loaded before
// they are used.
`include "huffman_table_bit_count_select_defines.svh"

module huffman_table_bit_count_select #(
    parameter int TABLE_DEPTH = htbcs_pkg::TABLE_DEPTH_DEF,
    parameter int CLAMP_LIMIT = htbcs_pkg::CLAMP_LIMIT_DEF,
    parameter int COST_WIDTH  = htbcs_pkg::COST_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [htbcs_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [htbcs_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // load_address, load_data, value_x, value_y, quad_pattern, zero pad
    input  logic [htbcs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic [htbcs_pkg::MODE_W-1:0]      s_axis_tuser,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // min_bits, table_choice, zero pad
    output logic [htbcs_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    htbcs_pkg::cfg_t      cfg_reg;
    htbcs_pkg::q_entry_t  push_entry, head_entry;
    htbcs_pkg::q_status_t q_status;
    logic                 q_push, q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.variant        <= htbcs_pkg::VARIANT_PAIR2;
            cfg_reg.row_width_log2 <= htbcs_pkg::ROW_WIDTH_RST;
            cfg_reg.clamp_enable   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                htbcs_pkg::REG_VARIANT:   cfg_reg.variant        <= cfg_wr_data[1:0];
                htbcs_pkg::REG_ROW_WIDTH: cfg_reg.row_width_log2 <= cfg_wr_data;
                htbcs_pkg::REG_CLAMP:     cfg_reg.clamp_enable   <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    htbcs_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .CLAMP_LIMIT (CLAMP_LIMIT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .q_pop         (q_pop),
        .q_push        (q_push),
        .q_push_entry  (push_entry)
    );

    htbcs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    htbcs_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .COST_WIDTH  (COST_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .variant       (cfg_reg.variant),
        .head_entry    (head_entry),
        .q_empty       (q_status.empty),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `HTBCS_ASSERT_NOW(a_no_push_full, aclk, aresetn, q_push, !q_status.full)
    `HTBCS_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, q_pop, !q_status.empty)
    `HTBCS_ASSERT_NOW(a_wide_choice, aclk, aresetn, m_axis_tvalid && m_axis_tdata[17],
                      cfg_reg.variant == htbcs_pkg::VARIANT_PAIR4)
    `HTBCS_ASSERT_NOW(a_full_stops_beats, aclk, aresetn, q_status.full, !s_axis_tready)

endmodule
